### rtl/dfr_pkg.sv
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants of the checked frame deframer: header layout,
// status codes, register indexes, result record and the crc-32c byte update.
// ----------------------------------------------------------------------------
package dfr_pkg;

    localparam int HEADER_BYTES = 24;
    localparam int HDR_CNT_W    = 5;

    // header byte offsets
    localparam logic [HDR_CNT_W-1:0] OFS_VERSION  = 5'd4;
    localparam logic [HDR_CNT_W-1:0] OFS_RESERVED = 5'd6;
    localparam logic [HDR_CNT_W-1:0] OFS_SEQUENCE = 5'd8;
    localparam logic [HDR_CNT_W-1:0] OFS_LENGTH   = 5'd16;
    localparam logic [HDR_CNT_W-1:0] OFS_CRC      = 5'd20;
    localparam logic [HDR_CNT_W-1:0] OFS_LAST     = 5'(HEADER_BYTES - 1);

    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_MAGIC   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_VERSION = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 2'd2;

    localparam logic [31:0] RST_FRAME_MAGIC   = 32'd0;
    localparam logic [15:0] RST_FRAME_VERSION = 16'd1;
    localparam logic [31:0] RST_MAX_PAYLOAD   = 32'd65536;

    // result status codes
    localparam logic [2:0] ST_BUSY        = 3'd0;
    localparam logic [2:0] ST_GOOD        = 3'd1;
    localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
    localparam logic [2:0] ST_BAD_VERSION = 3'd3;
    localparam logic [2:0] ST_TOO_LONG    = 3'd4;
    localparam logic [2:0] ST_CRC_BAD     = 3'd5;
    localparam logic [2:0] ST_FAILED      = 3'd6;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic [63:0] frame_sequence;
        logic [31:0] frame_length;
        logic        end_of_frame;
        logic [2:0]  status;
    } result_t;

    // reflected crc-32c over one byte, one bit per step
    function automatic logic [31:0] crc32c_byte(input logic [31:0] crc,
                                                input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

### rtl/dfr_if.sv
// ----------------------------------------------------------------------------
// dfr_if
// Valid/ready channels of the deframer: byte stream, results, register writes.
// ----------------------------------------------------------------------------
interface dfr_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface dfr_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic [63:0] frame_sequence;
    logic [31:0] frame_length;
    logic        end_of_frame;
    logic [2:0]  status;

    modport source (output valid, output payload_byte, output has_byte,
                    output frame_sequence, output frame_length,
                    output end_of_frame, output status, input ready);
    modport sink   (input valid, input payload_byte, input has_byte,
                    input frame_sequence, input frame_length,
                    input end_of_frame, input status, output ready);
endinterface

interface dfr_cfg_if
    import dfr_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [31:0]            data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/dfr_front.sv
// ----------------------------------------------------------------------------
// dfr_front
// Takes stream bytes, sorts them into header, payload or failed-stream bytes,
// checks the header, runs the payload crc and builds result records.
// ----------------------------------------------------------------------------
module dfr_front
    import dfr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    dfr_stream_if.sink         stream,
    dfr_cfg_if.sink            cfg,
    input  logic               queue_full,
    output logic               push,
    output result_t            push_data
);

    typedef enum logic [1:0] {
        PH_HEADER  = 2'b01,
        PH_PAYLOAD = 2'b10
    } phase_t;

    logic [31:0] frame_magic_reg;
    logic [15:0] frame_version_reg;
    logic [31:0] max_payload_reg;

    phase_t               phase_reg, phase_next;
    logic [HDR_CNT_W-1:0] count_reg, count_next;
    logic [31:0]          bytes_left_reg, bytes_left_next;
    logic                 failed_reg, failed_next;

    logic [31:0] magic_reg, magic_next;
    logic [15:0] version_reg, version_next;
    logic [63:0] sequence_reg, sequence_next;
    logic [31:0] length_reg, length_next;
    logic [31:0] exp_crc_reg, exp_crc_next;
    logic [31:0] crc_reg, crc_next;

    logic        accept;
    logic [7:0]  b;
    logic [31:0] crc_upd;
    logic [31:0] exp_crc_full;

    assign cfg.ready    = 1'b1;
    assign stream.ready = !queue_full;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.data_byte;
    assign crc_upd      = crc32c_byte(crc_reg, b);
    assign exp_crc_full = {b, exp_crc_reg[23:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_magic_reg   <= RST_FRAME_MAGIC;
            frame_version_reg <= RST_FRAME_VERSION;
            max_payload_reg   <= RST_MAX_PAYLOAD;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_FRAME_MAGIC:   frame_magic_reg   <= cfg.data;
                CFG_FRAME_VERSION: frame_version_reg <= cfg.data[15:0];
                CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg.data;
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        count_next      = count_reg;
        bytes_left_next = bytes_left_reg;
        failed_next     = failed_reg;
        magic_next      = magic_reg;
        version_next    = version_reg;
        sequence_next   = sequence_reg;
        length_next     = length_reg;
        exp_crc_next    = exp_crc_reg;
        crc_next        = crc_reg;
        push            = 1'b0;
        push_data       = '0;

        if (accept)
        begin
            if (failed_reg)
            begin
                push                   = 1'b1;
                push_data.end_of_frame = 1'b1;
                push_data.status       = ST_FAILED;
            end
            else if (phase_reg == PH_PAYLOAD)
            begin
                push                     = 1'b1;
                push_data.payload_byte   = b;
                push_data.has_byte       = 1'b1;
                push_data.frame_sequence = sequence_reg;
                push_data.frame_length   = length_reg;
                if (bytes_left_reg > 32'd1)
                begin
                    bytes_left_next  = bytes_left_reg - 32'd1;
                    crc_next         = crc_upd;
                    push_data.status = ST_BUSY;
                end
                else
                begin
                    bytes_left_next        = '0;
                    phase_next             = PH_HEADER;
                    crc_next               = CRC_INIT;
                    push_data.end_of_frame = 1'b1;
                    if (~crc_upd == exp_crc_reg)
                    begin
                        push_data.status = ST_GOOD;
                    end
                    else
                    begin
                        push_data.status = ST_CRC_BAD;
                        failed_next      = 1'b1;
                    end
                end
            end
            else
            begin
                phase_next = PH_HEADER;
                // byte lanes of the little-endian header fields
                priority if (count_reg < OFS_VERSION)
                    magic_next[count_reg[1:0]*8 +: 8] = b;
                else if (count_reg < OFS_RESERVED)
                    version_next[count_reg[0]*8 +: 8] = b;
                else if (count_reg < OFS_SEQUENCE)
                    ;
                else if (count_reg < OFS_LENGTH)
                    sequence_next[count_reg[2:0]*8 +: 8] = b;
                else if (count_reg < OFS_CRC)
                    length_next[count_reg[1:0]*8 +: 8] = b;
                else
                    exp_crc_next[count_reg[1:0]*8 +: 8] = b;

                if (count_reg != OFS_LAST)
                begin
                    count_next = count_reg + 5'd1;
                end
                else
                begin
                    count_next               = '0;
                    push_data.frame_sequence = sequence_reg;
                    push_data.frame_length   = length_reg;
                    push_data.end_of_frame   = 1'b1;
                    priority if (magic_reg != frame_magic_reg)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_BAD_MAGIC;
                        failed_next      = 1'b1;
                    end
                    else if (version_reg != frame_version_reg)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_BAD_VERSION;
                        failed_next      = 1'b1;
                    end
                    else if (length_reg > max_payload_reg)
                    begin
                        push             = 1'b1;
                        push_data.status = ST_TOO_LONG;
                        failed_next      = 1'b1;
                    end
                    else if (length_reg == '0)
                    begin
                        // empty payload: crc of nothing is zero
                        push     = 1'b1;
                        crc_next = CRC_INIT;
                        if (exp_crc_full == '0)
                        begin
                            push_data.status = ST_GOOD;
                        end
                        else
                        begin
                            push_data.status = ST_CRC_BAD;
                            failed_next      = 1'b1;
                        end
                    end
                    else
                    begin
                        crc_next        = CRC_INIT;
                        bytes_left_next = length_reg;
                        phase_next      = PH_PAYLOAD;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HEADER;
            count_reg      <= '0;
            bytes_left_reg <= '0;
            failed_reg     <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            count_reg      <= count_next;
            bytes_left_reg <= bytes_left_next;
            failed_reg     <= failed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        magic_reg    <= magic_next;
        version_reg  <= version_next;
        sequence_reg <= sequence_next;
        length_reg   <= length_next;
        exp_crc_reg  <= exp_crc_next;
        crc_reg      <= crc_next;
    end

endmodule

### rtl/dfr_queue.sv
// ----------------------------------------------------------------------------
// dfr_queue
// Result queue between the parser and the output channel; its head register
// drives the result channel directly. DEPTH from 2 up.
// ----------------------------------------------------------------------------
module dfr_queue
    import dfr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_t       push_data,
    output logic          full,
    dfr_result_if.source  result
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               pop;
    result_t            head;

    assign full         = (count_reg == CNT_W'(DEPTH));
    assign result.valid = (count_reg != '0);
    assign pop          = result.valid && result.ready;
    assign head         = mem_reg[rd_ptr_reg];

    assign result.payload_byte   = head.payload_byte;
    assign result.has_byte       = head.has_byte;
    assign result.frame_sequence = head.frame_sequence;
    assign result.frame_length   = head.frame_length;
    assign result.end_of_frame   = head.end_of_frame;
    assign result.status         = head.status;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/checked_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// checked_frame_deframer_top
// Length-prefixed frame deframer with crc-32c payload check.
//
//   channel   dir   handshake      payload
//   stream    in    valid/ready    data_byte
//   result    out   valid/ready    payload_byte, has_byte, frame_sequence,
//                                  frame_length, end_of_frame, status
//   cfg       in    valid/ready    index, data (ready is always high)
//
// one byte per cycle while the queue is not full; a byte's result, if any,
// is written into the queue as it transfers, built by the combinational
// parser and byte-wide crc update; the result queue holds QUEUE_DEPTH
// results; stream ready drops only while it is full, so a stalled result
// side stops the stream after QUEUE_DEPTH results
// reset clears the queue, the parser and the stream failure flag; registers
// return to magic 0, version 1, max payload 65536
// ----------------------------------------------------------------------------
module checked_frame_deframer_top
    import dfr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    dfr_stream_if.sink    stream,
    dfr_result_if.source  result,
    dfr_cfg_if.sink       cfg
);

    logic    push;
    logic    queue_full;
    result_t push_data;

    dfr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .cfg        (cfg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    dfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .result    (result)
    );

`ifndef SYNTHESIS
    // a stalled stream always has a result waiting
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !stream.ready |-> result.valid)
        else $error("stream stalled with empty result queue");

    // no push while the queue is full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        queue_full |-> !push)
        else $error("result pushed into full queue");

    // a failed-stream result carries nothing
    a_failed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ST_FAILED |->
            result.end_of_frame && !result.has_byte && result.frame_length == '0)
        else $error("failed-stream result carries data");

    // payload results only in progress or with a crc verdict
    a_byte_status: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.has_byte |->
            result.status == ST_BUSY || result.status == ST_GOOD ||
            result.status == ST_CRC_BAD)
        else $error("payload byte with header status");

    // a result held by a stall does not change
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> $stable(result.status) &&
            $stable(result.payload_byte))
        else $error("stalled result changed");
`endif

endmodule
